>>> src/lp5_pkg.sv
`default_nettype none
package lp5_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int CFG_ROWS_W  = 13;
   localparam int CFG_COLS_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ROWS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COLS = 8'd1;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = 2;
   localparam int OQ_CW    = 3;

   // position flags of one item, for its two possible results
   typedef struct packed {
      logic has_up;      // row above exists: emit its pixel
      logic up_border;   // that pixel is a border copy
      logic row_last;    // this item is in the last row: emit own copy
      logic frame_last;  // last item of the frame
   } lp5_pos_type;

endpackage
`default_nettype wire

>>> src/lp5_ctrl.sv
`default_nettype none
module lp5_ctrl
   import lp5_pkg::*;
#(
   parameter int MAX_ROWS = 4096,
   parameter int MAX_COLS = 1024,
   parameter int ROW_W    = 12,
   parameter int COL_W    = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic      [ROW_W-1:0]       row,
   output logic      [COL_W-1:0]       col,
   output lp5_pos_type                 pos
);

   localparam int RCFG_W = $clog2(MAX_ROWS + 1);
   localparam int CCFG_W = $clog2(MAX_COLS + 1);

   logic [RCFG_W-1:0] frame_rows_ff, frame_rows_in;
   logic [CCFG_W-1:0] frame_cols_ff, frame_cols_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CFG_ROWS_W-1:0] rows_val;
   logic [CFG_COLS_W-1:0] cols_val;
   logic row_last, col_last;

   assign rows_val = csr_wdata[CFG_ROWS_W-1:0];
   assign cols_val = csr_wdata[CFG_COLS_W-1:0];

   assign row_last = (RCFG_W'(row_ff) + RCFG_W'(1)) == frame_rows_ff;
   assign col_last = (CCFG_W'(col_ff) + CCFG_W'(1)) == frame_cols_ff;

   always_comb begin
      frame_rows_in = frame_rows_ff;
      frame_cols_in = frame_cols_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_ROWS: begin
               if (rows_val == '0) begin
                  frame_rows_in = RCFG_W'(1);
               end else if (int'(rows_val) > MAX_ROWS) begin
                  frame_rows_in = RCFG_W'(MAX_ROWS);
               end else begin
                  frame_rows_in = RCFG_W'(rows_val);
               end
            end
            CSR_FRAME_COLS: begin
               if (cols_val == '0) begin
                  frame_cols_in = CCFG_W'(1);
               end else if (int'(cols_val) > MAX_COLS) begin
                  frame_cols_in = CCFG_W'(MAX_COLS);
               end else begin
                  frame_cols_in = CCFG_W'(cols_val);
               end
            end
            default: begin
            end
         endcase
         row_in = '0;
         col_in = '0;
      end else if (step) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= RCFG_W'(16);
         frame_cols_ff <= CCFG_W'(16);
         row_ff        <= '0;
         col_ff        <= '0;
      end else begin
         frame_rows_ff <= frame_rows_in;
         frame_cols_ff <= frame_cols_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
      end
   end

   assign row = row_ff;
   assign col = col_ff;
   assign pos.has_up     = row_ff != '0;
   assign pos.up_border  = (row_ff == ROW_W'(1)) || (col_ff == '0) || col_last;
   assign pos.row_last   = row_last;
   assign pos.frame_last = row_last && col_last;

endmodule
`default_nettype wire

>>> src/lp5_rowmem.sv
`default_nettype none
module lp5_rowmem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int W     = 16
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [W-1:0]  wr_prev,
   input  wire logic [W-1:0]  wr_older,
   output logic      [W-1:0]  rd_prev,
   output logic      [W-1:0]  rd_prev_nx,
   output logic      [W-1:0]  rd_older
);

   logic [W-1:0]  prev_row_ff  [DEPTH];
   logic [W-1:0]  older_row_ff [DEPTH];
   logic [W-1:0]  rd_prev_ff, rd_prev_nx_ff, rd_older_ff;
   logic [AW-1:0] nx_addr;

   assign nx_addr = (rd_addr == AW'(DEPTH - 1)) ? '0 : rd_addr + AW'(1);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_prev_ff    <= prev_row_ff[rd_addr];
         rd_prev_nx_ff <= prev_row_ff[nx_addr];
         rd_older_ff   <= older_row_ff[rd_addr];
      end
      if (wr_en) begin
         prev_row_ff[wr_addr]  <= wr_prev;
         older_row_ff[wr_addr] <= wr_older;
      end
   end

   assign rd_prev    = rd_prev_ff;
   assign rd_prev_nx = rd_prev_nx_ff;
   assign rd_older   = rd_older_ff;

endmodule
`default_nettype wire

>>> src/lp5_outq.sv
`default_nettype none
module lp5_outq
   import lp5_pkg::*;
#(
   parameter int W = 42
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_a,
   input  wire logic [W-1:0] data_a,
   input  wire logic         push_b,
   input  wire logic [W-1:0] data_b,
   output logic              room2,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic      [W-1:0] out_data
);

   logic [W-1:0]     queue_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, b_ptr;
   logic [OQ_CW-1:0] count_ff, count_in;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign b_ptr     = wr_ptr_ff + OQ_AW'(push_a);
   assign wr_ptr_in = b_ptr + OQ_AW'(push_b);
   assign rd_ptr_in = rd_ptr_ff + OQ_AW'(pop);
   assign count_in  = count_ff + OQ_CW'(push_a) + OQ_CW'(push_b) - OQ_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         queue_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         queue_ff[b_ptr] <= data_b;
      end
   end

   assign room2     = count_ff <= OQ_CW'(OQ_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = queue_ff[rd_ptr_ff];

endmodule
`default_nettype wire

>>> src/laplacian_5point_stencil_unit.sv
`default_nettype none
// Five-point Laplacian over a raster-order frame, one sample per item.
// Path: an accepted item is registered in stage s1 and pushed into the result queue, which
// drives rsp_tvalid; stage s1 stalls while the queue lacks room for two results.
// Throughput: one item per cycle when s1 is not stalled, set by the row stores' single
// read/write slot; in the last row an item may yield two results, sent one at a time.
// Reset (synchronous): counters to zero, frame 16 x 16, pipeline and result queue
// empty; the row stores are not cleared.
module laplacian_5point_stencil_unit
   import lp5_pkg::*;
#(
   parameter int MAX_COLS    = 1024,
   parameter int MAX_ROWS    = 4096,
   parameter int SAMPLE_BITS = 16,
   localparam int RES_W       = SAMPLE_BITS + 3,
   localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int COL_W       = $clog2(MAX_COLS),
   localparam int REQ_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((RES_W + ROW_W + COL_W + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // sample
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,   // result_value, out_row, out_col
   output logic                        rsp_tlast,   // frame_last
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int QW = RES_W + ROW_W + COL_W + 1;

   logic        accept, s1_fire, fwd_in, room2;
   logic [ROW_W-1:0] cur_row;
   logic [COL_W-1:0] cur_col;
   lp5_pos_type cur_pos;

   logic                          s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;
   logic [ROW_W-1:0]              s1_row_ff;
   logic [COL_W-1:0]              s1_col_ff;
   lp5_pos_type                   s1_pos_ff;
   logic                          s1_fwd_ff;
   logic signed [SAMPLE_BITS-1:0] last_x_ff, last_center_ff;

   logic [SAMPLE_BITS-1:0]        rd_prev, rd_prev_nx, rd_older;
   logic signed [SAMPLE_BITS-1:0] center, up, left, right;
   logic signed [RES_W-1:0]       lap, val_a, val_b;
   logic [QW-1:0]                 data_a, data_b, q_data;

   assign csr_ready  = 1'b1;
   assign s1_fire    = s1_valid_ff && room2;
   assign req_tready = !s1_valid_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;
   assign fwd_in     = s1_valid_ff && (s1_col_ff == cur_col);

   lp5_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .ROW_W    (ROW_W),
      .COL_W    (COL_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .row       (cur_row),
      .col       (cur_col),
      .pos       (cur_pos)
   );

   lp5_rowmem #(
      .DEPTH (MAX_COLS),
      .AW    (COL_W),
      .W     (SAMPLE_BITS)
   ) u_rowmem (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (cur_col),
      .wr_en      (s1_fire),
      .wr_addr    (s1_col_ff),
      .wr_prev    (s1_x_ff),
      .wr_older   (center),
      .rd_prev    (rd_prev),
      .rd_prev_nx (rd_prev_nx),
      .rd_older   (rd_older)
   );

   // single-column frames read the entry the previous item is writing
   assign center = s1_fwd_ff ? last_x_ff : $signed(rd_prev);
   assign up     = s1_fwd_ff ? last_center_ff : $signed(rd_older);
   assign left   = last_center_ff;
   assign right  = $signed(rd_prev_nx);

   assign lap = RES_W'(up) + RES_W'(s1_x_ff) + RES_W'(left) + RES_W'(right)
              - (RES_W'(center) <<< 2);
   assign val_a = s1_pos_ff.up_border ? RES_W'(center) : lap;
   assign val_b = RES_W'(s1_x_ff);

   assign data_a = {1'b0, s1_col_ff, s1_row_ff - ROW_W'(1), val_a};
   assign data_b = {s1_pos_ff.frame_last, s1_col_ff, s1_row_ff, val_b};

   assign s1_valid_in = accept || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff   <= $signed(req_tdata[SAMPLE_BITS-1:0]);
         s1_row_ff <= cur_row;
         s1_col_ff <= cur_col;
         s1_pos_ff <= cur_pos;
         s1_fwd_ff <= fwd_in;
      end
      if (s1_fire) begin
         last_x_ff      <= s1_x_ff;
         last_center_ff <= center;
      end
   end

   lp5_outq #(
      .W (QW)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_a    (s1_fire && s1_pos_ff.has_up),
      .data_a    (data_a),
      .push_b    (s1_fire && s1_pos_ff.row_last),
      .data_b    (data_b),
      .room2     (room2),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_data)
   );

   assign rsp_tdata = RSP_TDATA_W'(q_data[QW-2:0]);
   assign rsp_tlast = q_data[QW-1];

   a_accept_frees_s1: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff) |-> s1_fire)
      else $error("item accepted over a stalled stage");

   a_accept_loads_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item missing from stage");

   a_fwd_single_col: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> (s1_col_ff == '0))
      else $error("forwarding outside a single-column frame");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("waiting result changed or dropped");

endmodule
`default_nettype wire
